@@ src/bse_pkg.sv @@
// ----------------------------------------------------------------------------
// bse_pkg: shared types and constants of the bounded stack engine
// Sizes, operation and status codes, control structs and ring arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

  // Storage sizes
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned FILL_W      = $clog2(STACK_DEPTH + 1);

  // Field widths
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned DEPTH_OUT_W = 5;

  // Width wide enough for the fill count and the requested position
  localparam int unsigned CMP_W = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;
  localparam int unsigned EXT_W = (CMP_W > DEPTH_OUT_W) ? CMP_W : DEPTH_OUT_W;

  // Fixed position and kept entry count of the third-from-bottom request
  localparam int unsigned THIRD_POS  = 3;
  localparam int unsigned KEEP_COUNT = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_PEEK   = 3'd2,
    MODE_READN  = 3'd3,
    MODE_POPN   = 3'd4,
    MODE_BOTTOM = 3'd5,
    MODE_DRAIN  = 3'd6,
    MODE_THIRD  = 3'd7
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_SHORT     = 2'd3
  } status_e;

  // Entry store access for one request
  typedef struct packed {
    logic             we;
    logic             re;
    logic [PTR_W-1:0] addr;
  } mem_req_t;

  // Result information that travels beside the read data
  typedef struct packed {
    status_e                status;
    logic [DEPTH_OUT_W-1:0] depth;
    logic                   use_read;
  } res_info_t;

  // Add an offset to a ring position, wrapping at the stack depth
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (PTR_W + 1)'(STACK_DEPTH)) begin
      sum = sum - (PTR_W + 1)'(STACK_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/bse_ram.sv @@
// ----------------------------------------------------------------------------
// bse_ram: entry store of the bounded stack engine
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on request
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read on request, hold the last word otherwise
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/bse_ctrl.sv @@
// ----------------------------------------------------------------------------
// bse_ctrl: stack pointer control of the bounded stack engine
// Decodes a request, picks the entry to touch and updates fill and base.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [bse_pkg::MODE_W-1:0]  mode_i,
  input  wire logic [bse_pkg::COUNT_W-1:0] count_n_i,
  output bse_pkg::mem_req_t                mem_req_o,
  output bse_pkg::res_info_t               info_o
);

  // Entries live in a ring: logical index i sits at base + i
  logic [bse_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [bse_pkg::PTR_W-1:0]  base_q, base_d;

  logic [bse_pkg::CMP_W-1:0]  fill_ext;
  logic [bse_pkg::CMP_W-1:0]  cnt_ext;
  logic [bse_pkg::CMP_W-1:0]  idx;
  logic [bse_pkg::CMP_W-1:0]  shift;
  logic [bse_pkg::EXT_W-1:0]  depth_ext;
  bse_pkg::status_e           status;
  logic                       use_read;
  logic                       we;

  assign fill_ext = bse_pkg::CMP_W'(fill_q);
  assign cnt_ext  = bse_pkg::CMP_W'(count_n_i);
  assign shift    = fill_ext - bse_pkg::CMP_W'(bse_pkg::KEEP_COUNT);

  // Decode the request
  always_comb begin
    fill_d   = fill_q;
    base_d   = base_q;
    idx      = '0;
    status   = bse_pkg::ST_OK;
    use_read = 1'b0;
    we       = 1'b0;
    case (bse_pkg::mode_e'(mode_i))
      bse_pkg::MODE_PUSH: begin
        if (fill_ext >= bse_pkg::CMP_W'(bse_pkg::STACK_DEPTH)) begin
          status = bse_pkg::ST_OVERFLOW;
        end else begin
          we     = 1'b1;
          idx    = fill_ext;
          fill_d = fill_q + bse_pkg::FILL_W'(1);
        end
      end
      bse_pkg::MODE_POP, bse_pkg::MODE_PEEK: begin
        if (fill_q == '0) begin
          status = bse_pkg::ST_UNDERFLOW;
        end else begin
          use_read = 1'b1;
          idx      = fill_ext - bse_pkg::CMP_W'(1);
          if (bse_pkg::mode_e'(mode_i) == bse_pkg::MODE_POP) begin
            fill_d = fill_q - bse_pkg::FILL_W'(1);
          end
        end
      end
      bse_pkg::MODE_READN, bse_pkg::MODE_POPN: begin
        if (cnt_ext > fill_ext) begin
          status = bse_pkg::ST_UNDERFLOW;
        end else if (cnt_ext != '0) begin
          use_read = 1'b1;
          idx      = fill_ext - cnt_ext;
          if (bse_pkg::mode_e'(mode_i) == bse_pkg::MODE_POPN) begin
            fill_d = bse_pkg::FILL_W'(fill_ext - cnt_ext);
          end
        end
      end
      bse_pkg::MODE_BOTTOM, bse_pkg::MODE_DRAIN: begin
        if (fill_q != '0) begin
          use_read = 1'b1;
        end
        if (bse_pkg::mode_e'(mode_i) == bse_pkg::MODE_DRAIN) begin
          fill_d = '0;
        end
      end
      bse_pkg::MODE_THIRD: begin
        if (fill_ext < bse_pkg::CMP_W'(bse_pkg::THIRD_POS)) begin
          status = bse_pkg::ST_SHORT;
        end else begin
          use_read = 1'b1;
          idx      = bse_pkg::CMP_W'(bse_pkg::THIRD_POS - 1);
          // Keep the top four: move the base up instead of the words
          if (fill_ext > bse_pkg::CMP_W'(bse_pkg::KEEP_COUNT)) begin
            base_d = bse_pkg::ring_add(base_q, shift[bse_pkg::PTR_W-1:0]);
            fill_d = bse_pkg::FILL_W'(bse_pkg::KEEP_COUNT);
          end
        end
      end
      default: begin
        status = bse_pkg::ST_OK;
      end
    endcase
  end

  assign depth_ext = bse_pkg::EXT_W'(fill_d);

  // Drive the entry store and the result information
  always_comb begin
    mem_req_o.we   = accept_i & we;
    mem_req_o.re   = accept_i & use_read;
    mem_req_o.addr = bse_pkg::ring_add(base_q, idx[bse_pkg::PTR_W-1:0]);
    info_o.status   = status;
    info_o.depth    = depth_ext[bse_pkg::DEPTH_OUT_W-1:0];
    info_o.use_read = use_read;
  end

  // Advance the pointers on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      base_q <= '0;
    end else if (accept_i) begin
      fill_q <= fill_d;
      base_q <= base_d;
    end
  end

endmodule

`default_nettype wire

@@ src/bounded_stack_engine_top.sv @@
// ----------------------------------------------------------------------------
// bounded_stack_engine_top: bounded LIFO stack of signed 32-bit words
// Takes one request per cycle unless a held result stalls it, and returns value, status and new depth.
// ----------------------------------------------------------------------------
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while no held result stalls the input; the entry store has one write and one
// registered read port, and each request uses at most one of them.
// Reset: asynchronous, active low; empties the stack and drops any result.
// The entry store is not cleared; only written entries are ever read.
`default_nettype none

module bounded_stack_engine_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic        [bse_pkg::MODE_W-1:0]    mode_i,
  input  wire logic signed [bse_pkg::WORD_W-1:0]    value_i,
  input  wire logic        [bse_pkg::COUNT_W-1:0]   count_n_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed      [bse_pkg::WORD_W-1:0]    result_value_o,
  output logic             [bse_pkg::STATUS_W-1:0]  status_o,
  output logic             [bse_pkg::DEPTH_OUT_W-1:0] depth_after_o
);

  logic                        accept;
  logic                        out_valid_q, out_valid_d;
  bse_pkg::res_info_t          info;
  bse_pkg::res_info_t          info_q;
  bse_pkg::mem_req_t           mem_req;
  logic [bse_pkg::WORD_W-1:0]  rdata;

  // Take a request whenever the result register is free or being emptied
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  bse_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .mode_i    (mode_i),
    .count_n_i (count_n_i),
    .mem_req_o (mem_req),
    .info_o    (info)
  );

  bse_ram #(
    .WIDTH (bse_pkg::WORD_W),
    .DEPTH (bse_pkg::STACK_DEPTH),
    .AW    (bse_pkg::PTR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.addr),
    .wdata_i (value_i),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.addr),
    .rdata_o (rdata)
  );

  // Hold the result until it is taken
  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the result information with the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      info_q <= info;
    end
  end

  // Drive the result; a request that reads nothing returns zero
  assign out_valid_o    = out_valid_q;
  assign result_value_o = info_q.use_read ? signed'(rdata) : '0;
  assign status_o       = info_q.status;
  assign depth_after_o  = info_q.depth;

endmodule

`default_nettype wire
